// File: design/pe_pkg.sv
package pe_pkg;

  localparam int Q_W    = 32;
  localparam int FRAC_W = 16;
  localparam int PROD_W = 2 * Q_W;
  localparam int SUM_W  = PROD_W - FRAC_W + 1;
  localparam int CFG_W  = 5;
  localparam int IDX_W_IN = 5;

  typedef logic signed [Q_W-1:0] q_t;

  typedef struct packed {
    logic clear;
    logic mul_en;
    logic add_en;
  } pe_mac_ctl_t;

endpackage

// File: design/polynomial_evaluator_top.sv
// Horner polynomial evaluator, signed Q16.16.
// Input: an item is taken on a clock edge with start high and busy low.
//   in_kind 0 writes in_coef_value to power in_coef_index (ignored above
//   MAX_POWER), no result. in_kind 1 evaluates at in_x_value.
// Config: cfg_data sets the degree in use, clamped to MAX_POWER; write it
//   with cfg_valid while idle (cfg_ready is high when not busy).
// Result: out_result_value and out_overflow are shown for one cycle with
//   out_valid high; the receiver must take the beat then.
// Sequence: each Horner step is a multiply state then an add/saturate state,
//   with the next coefficient read from the table during the add. An
//   evaluation runs one step per power from the degree down to zero; out_valid
//   rises as the last add is registered, and a new item can be taken in that
//   cycle, since busy is already low.
//   A write takes effect at its accepting edge, before any later read.
// Reset: clears the coefficient table (per-entry valid bits), the degree
//   and the sequencer; the block is ready in the cycle after reset.
module polynomial_evaluator_top #(
  parameter int MAX_POWER = 20
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_kind,
  input  logic [pe_pkg::IDX_W_IN-1:0] in_coef_index,
  input  logic signed [pe_pkg::Q_W-1:0] in_coef_value,
  input  logic signed [pe_pkg::Q_W-1:0] in_x_value,
  output logic                      out_valid,
  output logic signed [pe_pkg::Q_W-1:0] out_result_value,
  output logic                      out_overflow,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [pe_pkg::CFG_W-1:0]  cfg_data
);
  import pe_pkg::*;

  localparam int DEPTH = MAX_POWER + 1;
  localparam int IDX_W = $clog2(DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_ADD  = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] degree_r, degree_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;
  logic             wr_en;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  pe_mac_ctl_t      mac_ctl;
  q_t               coef;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign wr_en     = accept && !in_kind && (int'(in_coef_index) <= MAX_POWER);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    degree_nxt    = degree_r;
    out_valid_nxt = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = degree_r;
    mac_ctl       = '0;

    if (cfg_valid && cfg_ready) begin
      if (int'(cfg_data) > MAX_POWER) begin
        degree_nxt = IDX_W'(MAX_POWER);
      end else begin
        degree_nxt = IDX_W'(cfg_data);
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (accept && in_kind) begin
          mac_ctl.clear = 1'b1;
          rd_en         = 1'b1;
          rd_addr       = degree_r;
          idx_nxt       = degree_r;
          state_nxt     = ST_MUL;
        end
      end
      ST_MUL: begin
        mac_ctl.mul_en = 1'b1;
        state_nxt      = ST_ADD;
      end
      ST_ADD: begin
        mac_ctl.add_en = 1'b1;
        if (idx_r == '0) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          // fetch the next lower coefficient while this step closes
          rd_en     = 1'b1;
          rd_addr   = idx_r - IDX_W'(1);
          idx_nxt   = idx_r - IDX_W'(1);
          state_nxt = ST_MUL;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      degree_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      degree_r    <= degree_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
  end

  pe_coef_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (IDX_W)
  ) u_coef_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (IDX_W'(in_coef_index)),
    .wr_data (in_coef_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_coef (coef)
  );

  pe_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .x_in (in_x_value),
    .coef (coef),
    .acc  (out_result_value),
    .ovf  (out_overflow)
  );

  assign out_valid = out_valid_r;

endmodule

// File: design/pe_coef_mem.sv
module pe_coef_mem #(
  parameter int DEPTH  = 21,
  parameter int ADDR_W = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  pe_pkg::q_t           wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output pe_pkg::q_t           rd_coef
);
  import pe_pkg::*;

  q_t               mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  q_t               rd_data_r;
  logic             rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_coef = rd_valid_r ? rd_data_r : '0;

endmodule

// File: design/pe_mac.sv
module pe_mac (
  input  logic               clk,
  input  pe_pkg::pe_mac_ctl_t ctl,
  input  pe_pkg::q_t         x_in,
  input  pe_pkg::q_t         coef,
  output pe_pkg::q_t         acc,
  output logic               ovf
);
  import pe_pkg::*;

  q_t                       x_r;
  q_t                       acc_r;
  logic                     ovf_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0]  sum;
  logic                     sat;
  q_t                       acc_nxt;

  // floor of product / 2^16 is the arithmetic top slice
  always_comb begin
    sum = SUM_W'(signed'(prod_r[PROD_W-1:FRAC_W])) + SUM_W'(coef);
    sat = (sum[SUM_W-1:Q_W-1] != '0) && (sum[SUM_W-1:Q_W-1] != '1);
    if (!sat) begin
      acc_nxt = sum[Q_W-1:0];
    end else if (sum[SUM_W-1]) begin
      acc_nxt = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      acc_nxt = {1'b0, {(Q_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      x_r   <= x_in;
      acc_r <= '0;
      ovf_r <= 1'b0;
    end else if (ctl.add_en) begin
      acc_r <= acc_nxt;
      ovf_r <= ovf_r | sat;
    end
    if (ctl.mul_en) begin
      prod_r <= acc_r * x_r;
    end
  end

  assign acc = acc_r;
  assign ovf = ovf_r;

endmodule

// File: tb/sv/polynomial_evaluator_top_tb.sv
module polynomial_evaluator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pe_pkg::*;

  localparam int MAX_POWER = 20;
  localparam int PHASES = 16;
  localparam int ITEMS_PER_PHASE = 85;

  localparam q_t Q_ONE = 32'sh0001_0000;
  localparam q_t Q_MAX = 32'sh7fff_ffff;
  localparam q_t Q_MIN = 32'sh8000_0000;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_EVAL  = 1'b1
  } item_kind_t;

  typedef struct packed {
    q_t   value;
    logic overflow;
  } poly_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                in_kind = 1'b0;
  logic [IDX_W_IN-1:0] in_coef_index = '0;
  q_t                  in_coef_value = '0;
  q_t                  in_x_value = '0;
  logic                out_valid;
  q_t                  out_result_value;
  logic                out_overflow;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data = '0;

  // Shadow of the block's state
  q_t           coef_shadow [0:MAX_POWER];
  int unsigned  degree_shadow;
  poly_result_t pending_results[$];

  bit start_hi;
  bit idle_off;
  int mismatches;
  int n_writes;
  int n_evals;
  int n_results;
  int n_saturated;
  int n_degree_writes;

  polynomial_evaluator_top #(
    .MAX_POWER(MAX_POWER)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_coef_index    (in_coef_index),
    .in_coef_value    (in_coef_value),
    .in_x_value       (in_x_value),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_overflow     (out_overflow),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always #6 clk = ~clk;

  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

  // Horner's rule, product floored to Q16.16, sum clamped at every step
  function automatic poly_result_t horner_predict(q_t x);
    longint       acc;
    int           i;
    poly_result_t r;
    acc = 0;
    r.overflow = 1'b0;
    for (i = int'(degree_shadow); i >= 0; i--) begin
      acc = ((acc * longint'(x)) >>> FRAC_W) + longint'(coef_shadow[i]);
      if (acc > longint'(Q_MAX)) begin
        acc = longint'(Q_MAX);
        r.overflow = 1'b1;
      end else if (acc < longint'(Q_MIN)) begin
        acc = longint'(Q_MIN);
        r.overflow = 1'b1;
      end
    end
    r.value = acc[Q_W-1:0];
    return r;
  endfunction

  // Mostly small magnitudes so deep polynomials stay in range, plus full range and corners
  function automatic q_t rand_q();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return q_t'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      6, 7: return q_t'($urandom);
      8: return q_t'($urandom_range(0, 32'h0000_ffff)) - 32'sh0000_8000;
      default: begin
        case ($urandom_range(0, 4))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return '0;
          3: return Q_ONE;
          default: return -Q_ONE;
        endcase
      end
    endcase
  endfunction

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (idle_off || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Hold start until the beat is taken, then update the shadow state
  task automatic send_item(item_kind_t kind, logic [IDX_W_IN-1:0] idx, q_t coef, q_t x,
                           int gap);
    start <= 1'b1;
    start_hi = 1'b1;
    in_kind <= kind;
    in_coef_index <= idx;
    in_coef_value <= coef;
    in_x_value <= x;
    do @(posedge clk); while (busy !== 1'b0);
    if (kind == KIND_WRITE) begin
      n_writes++;
      if (idx <= MAX_POWER) coef_shadow[idx] = coef;
    end else begin
      n_evals++;
      pending_results.push_back(horner_predict(x));
    end
    if (gap > 0) begin
      start <= 1'b0;
      start_hi = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    if (start_hi) begin
      start <= 1'b0;
      start_hi = 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
    // let a trailing coefficient write settle
    repeat (4) @(posedge clk);
  endtask

  task automatic write_degree(logic [CFG_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    degree_shadow = (value > MAX_POWER) ? MAX_POWER : value;
    n_degree_writes++;
  endtask

  task automatic test_reset_state();
    send_item(KIND_EVAL, 5'd7, Q_MAX, Q_MAX, rand_gap());
    send_item(KIND_EVAL, 5'd31, Q_MIN, Q_MIN, rand_gap());
  endtask

  task automatic test_degree_clamp();
    write_degree(5'd31);
    send_item(KIND_WRITE, 5'd20, Q_ONE, q_t'($urandom), rand_gap());
    send_item(KIND_WRITE, 5'd21, Q_MAX, q_t'($urandom), rand_gap());
    send_item(KIND_WRITE, 5'd31, Q_MIN, q_t'($urandom), rand_gap());
    send_item(KIND_EVAL, 5'd20, Q_MAX, Q_ONE, rand_gap());
    write_degree(5'(MAX_POWER));
    send_item(KIND_EVAL, 5'd0, Q_MIN, -Q_ONE, rand_gap());
    write_degree(5'd0);
    send_item(KIND_EVAL, 5'd20, q_t'($urandom), Q_ONE, rand_gap());
  endtask

  task automatic test_saturation();
    write_degree(5'd1);
    send_item(KIND_WRITE, 5'd0, Q_MAX, q_t'($urandom), rand_gap());
    send_item(KIND_WRITE, 5'd1, Q_MAX, q_t'($urandom), rand_gap());
    send_item(KIND_EVAL, 5'd0, '0, 2 * Q_ONE, rand_gap());
    send_item(KIND_WRITE, 5'd1, Q_MIN, q_t'($urandom), rand_gap());
    send_item(KIND_EVAL, 5'd0, '0, 2 * Q_ONE, rand_gap());
    send_item(KIND_EVAL, 5'd0, '0, Q_MIN, rand_gap());
    send_item(KIND_EVAL, 5'd0, '0, '0, rand_gap());
  endtask

  task automatic test_truncation();
    write_degree(5'd2);
    send_item(KIND_WRITE, 5'd2, 32'sh0000_8000, '0, rand_gap());
    send_item(KIND_WRITE, 5'd1, -Q_ONE + 1, '0, rand_gap());
    send_item(KIND_WRITE, 5'd0, '0, '0, rand_gap());
    // smallest negative x: a product just below zero floors to minus one
    send_item(KIND_EVAL, 5'd0, '0, 32'shffff_ffff, rand_gap());
    send_item(KIND_EVAL, 5'd0, '0, 3 * Q_ONE, rand_gap());
    send_item(KIND_EVAL, 5'd0, '0, -(5 * Q_ONE / 2), rand_gap());
  endtask

  task automatic test_random();
    int               phase;
    int               n;
    int               k;
    logic [CFG_W-1:0] deg;
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: deg = 5'(MAX_POWER);
        1: deg = '0;
        2: deg = 5'd31;
        default: deg = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                  : 5'($urandom_range(0, 6));
      endcase
      write_degree(deg);
      idle_off = ($urandom_range(0, 3) == 0);
      // in the first three phases and at random after, reload the whole table, then mix writes and evaluations
      if (phase < 3 || $urandom_range(0, 1) == 1) begin
        for (k = 0; k <= MAX_POWER; k++) begin
          send_item(KIND_WRITE, 5'(k), rand_q(), q_t'($urandom), rand_gap());
        end
      end
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ((phase == 3 && n == 40) || $urandom_range(0, 149) == 0) wait_idle();
        if ($urandom_range(0, 1) == 1) begin
          send_item(KIND_EVAL, 5'($urandom), q_t'($urandom), rand_q(), rand_gap());
        end else if ($urandom_range(0, 6) == 0) begin
          send_item(KIND_WRITE, 5'($urandom_range(MAX_POWER + 1, 31)), q_t'($urandom),
                    q_t'($urandom), rand_gap());
        end else begin
          send_item(KIND_WRITE, 5'($urandom_range(0, MAX_POWER)), rand_q(), q_t'($urandom),
                    rand_gap());
        end
      end
    end
    idle_off = 1'b0;
  endtask

  always @(posedge clk) begin
    poly_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      n_results++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result %h ovf %b with none expected", $realtime,
                   out_result_value, out_overflow);
        end
      end else begin
        want = pending_results.pop_front();
        if (want.overflow) n_saturated++;
        if (out_result_value !== want.value || out_overflow !== want.overflow) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: expected value %h ovf %b, got value %h ovf %b", $realtime,
                     want.value, want.overflow, out_result_value, out_overflow);
          end
        end
      end
    end
  end

  initial begin
    int i;
    for (i = 0; i <= MAX_POWER; i++) coef_shadow[i] = '0;
    degree_shadow = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_degree_clamp();
    test_saturation();
    test_truncation();
    test_random();

    wait_idle();
    repeat (60) @(posedge clk);

    $display("Covered %0d coefficient writes, %0d evaluations and %0d degree settings",
             n_writes, n_evals, n_degree_writes);
    $display("Checked %0d results, %0d saturated, %0d mismatches",
             n_results, n_saturated, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
